@@ hw/rtl/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg
// shared constants and state codes for the pivot partition block
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_COORD_BITS = 32;
  localparam int LOW_COUNT_BITS = 7;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_RD   = 4'b0010,
    S_CHK  = 4'b0100,
    S_OUT  = 4'b1000
  } spp_state_t;

endpackage

@@ hw/rtl/spp_if.sv @@
// ----------------------------------------------------------------------------
// spp_if
// valid/ready channels for points, results and the pivot register write
// ----------------------------------------------------------------------------
interface spp_pt_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         is_last_in;

  modport source (output valid, point_x, point_y, is_last_in, input ready);
  modport sink   (input valid, point_x, point_y, is_last_in, output ready);
endinterface

interface spp_res_if #(parameter int COORD_BITS = 32, parameter int LC_BITS = 7);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         below_pivot;
  logic [LC_BITS-1:0]           low_count;
  logic                         dropped;
  logic                         is_last_out;

  modport source (output valid, out_x, out_y, below_pivot, low_count, dropped,
                  is_last_out, input ready);
  modport sink   (input valid, out_x, out_y, below_pivot, low_count, dropped,
                  is_last_out, output ready);
endinterface

interface spp_cfg_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pivot_x;

  modport source (output valid, pivot_x, input ready);
  modport sink   (input valid, pivot_x, output ready);
endinterface

@@ hw/rtl/spp_ram.sv @@
// ----------------------------------------------------------------------------
// spp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module spp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/spp_cls.sv @@
// ----------------------------------------------------------------------------
// spp_cls
// classifies an incoming point against the pivot and packs the store entry
// ----------------------------------------------------------------------------
module spp_cls #(
  parameter int COORD_BITS = 32
) (
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] pivot_x,
  output logic [2*COORD_BITS:0]        entry
);

  logic is_low;

  // signed compare, the class is fixed here at load time
  assign is_low = point_x < pivot_x;
  assign entry  = {is_low, point_y, point_x};

endmodule

@@ hw/rtl/stable_pivot_partition.sv @@
// ----------------------------------------------------------------------------
// stable_pivot_partition
// stable low/high partition of a run of 2-D points around a pivot x
// ----------------------------------------------------------------------------
// Points load one per cycle into a MAX_POINTS-entry store, each tagged low
// when its x is below the pivot in force at that moment. The item marked last
// ends the run; the block then stops taking points and scans the store twice,
// first emitting the low points, then the others, each in arrival order. Each
// scanned entry goes through a registered store read, then a match check,
// and a matching entry holds the output register until taken; only then
// does the scan go on. Points past capacity are dropped and flagged on every
// result.
// ----------------------------------------------------------------------------
module stable_pivot_partition
  import spp_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  spp_pt_if.sink     in_pt,
  spp_res_if.source  out_res,
  spp_cfg_if.sink    cfg_wr
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = 2 * COORD_BITS + 1;

  spp_state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] tally_r, tally_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          pass_r, pass_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic signed [COORD_BITS-1:0] pivot_r;

  logic          ovld_r, ovld_nxt;
  logic signed [COORD_BITS-1:0] ox_r, ox_nxt;
  logic signed [COORD_BITS-1:0] oy_r, oy_nxt;
  logic          obp_r, obp_nxt;
  logic          olast_r, olast_nxt;

  logic          in_acc, out_acc, has_room, end_idx, match;
  logic          ram_we, ram_re;
  logic [EW-1:0] wentry, rentry;

  assign in_pt.ready  = (state_r == S_LOAD);
  assign in_acc       = in_pt.valid && in_pt.ready;
  assign out_acc      = out_res.valid && out_res.ready;
  assign cfg_wr.ready = 1'b1;
  assign has_room     = fill_r < CW'(MAX_POINTS);
  assign ram_we       = in_acc && has_room;
  assign ram_re       = (state_r == S_RD);
  assign end_idx      = (CW'(idx_r) + CW'(1)) == fill_r;
  assign match        = rentry[EW-1] == !pass_r;

  spp_cls #(.COORD_BITS(COORD_BITS)) u_cls (
    .point_x (in_pt.point_x),
    .point_y (in_pt.point_y),
    .pivot_x (pivot_r),
    .entry   (wentry)
  );

  spp_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (wentry),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (rentry)
  );

  always_comb begin
    logic advance;
    advance   = 1'b0;
    state_nxt = state_r;
    fill_nxt  = fill_r;
    tally_nxt = tally_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    emit_nxt  = emit_r;
    ovld_nxt  = ovld_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    obp_nxt   = obp_r;
    olast_nxt = olast_r;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            fill_nxt  = fill_r + CW'(1);
            tally_nxt = tally_r + CW'(wentry[EW-1]);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_pt.is_last_in) begin
            idx_nxt   = '0;
            pass_nxt  = 1'b0;
            emit_nxt  = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (match) begin
          ovld_nxt  = 1'b1;
          ox_nxt    = rentry[COORD_BITS-1:0];
          oy_nxt    = rentry[2*COORD_BITS-1:COORD_BITS];
          obp_nxt   = !pass_r;
          olast_nxt = (emit_r + CW'(1)) == fill_r;
          state_nxt = S_OUT;
        end else begin
          advance = 1'b1;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          ovld_nxt = 1'b0;
          emit_nxt = emit_r + CW'(1);
          advance  = 1'b1;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (advance) begin
      if (!end_idx) begin
        idx_nxt   = idx_r + AW'(1);
        state_nxt = S_RD;
      end else if (!pass_r) begin
        idx_nxt   = '0;
        pass_nxt  = 1'b1;
        state_nxt = S_RD;
      end else begin
        fill_nxt  = '0;
        tally_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_LOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      fill_r  <= '0;
      tally_r <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      pass_r  <= 1'b0;
      emit_r  <= '0;
      ovld_r  <= 1'b0;
      pivot_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      tally_r <= tally_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      pass_r  <= pass_nxt;
      emit_r  <= emit_nxt;
      ovld_r  <= ovld_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        pivot_r <= cfg_wr.pivot_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    obp_r   <= obp_nxt;
    olast_r <= olast_nxt;
  end

  assign out_res.valid       = ovld_r;
  assign out_res.out_x       = ox_r;
  assign out_res.out_y       = oy_r;
  assign out_res.below_pivot = obp_r;
  assign out_res.low_count   = LOW_COUNT_BITS'(tally_r);
  assign out_res.dropped     = ovf_r;
  assign out_res.is_last_out = olast_r;

  // no point is taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_pt.ready && out_res.valid))
    else $error("input ready while a result is pending");

  // low points all come out in the first pass
  a_class_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.below_pivot == !pass_r))
    else $error("result class does not match scan pass");

  // never more results than stored points
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (emit_r < fill_r))
    else $error("more results than stored points");

  // after the final result the run is closed or the scan goes on with no result pending
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.ready && out_res.is_last_out) |=>
      (in_pt.ready || (!out_res.valid && emit_r == fill_r)))
    else $error("run not closed after final result");

endmodule
